FILE: rtl/core/ccr_pkg.sv
// Shared types and constants of the closed Catmull-Rom spline evaluator.
`timescale 1ns / 1ps
`default_nettype none
package ccr_pkg;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 7;
    localparam int COORD_W    = 32;
    localparam int POINT_W    = 3 * COORD_W;
    localparam int FRAC_W     = 16;
    localparam int COEF_W     = 38;
    localparam int ACC_W      = 40;
    localparam int PROD_W     = COEF_W + FRAC_W + 2;

    localparam logic [CNT_W-1:0] COUNT_RESET = 7'd4;
    localparam logic             FUNC_WRITE  = 1'b0;
    localparam logic             FUNC_EVAL   = 1'b1;

    // One item as it waits between the front and the back.
    typedef struct packed {
        logic               func;
        logic [IDX_W-1:0]   slot;
        logic [POINT_W-1:0] point;
        logic [IDX_W-1:0]   first_idx;
        logic [CNT_W-1:0]   count;
        logic [FRAC_W-1:0]  frac;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_COEF, ST_USQ, ST_MAC, ST_FIN, ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        DST_U2, DST_U3, DST_POS, DST_DER
    } t_dst;
endpackage
`default_nettype wire

FILE: rtl/core/ccr_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ccr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire  [$clog2(DEPTH)-1:0]  i_addr,
    input  wire  [WIDTH-1:0]          i_wdata,
    output logic [WIDTH-1:0]          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/ccr_front.sv
// Front end: point count register, segment computation and a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module ccr_front (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire  [ccr_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  wire                         i_push,
    output logic                        o_full,
    input  wire                         i_func,
    input  wire  [ccr_pkg::IDX_W-1:0]   i_point_index,
    input  wire  [ccr_pkg::COORD_W-1:0] i_coord_x,
    input  wire  [ccr_pkg::COORD_W-1:0] i_coord_y,
    input  wire  [ccr_pkg::COORD_W-1:0] i_coord_z,
    input  wire  [ccr_pkg::FRAC_W-1:0]  i_global_t,
    output logic                        o_q_valid,
    output ccr_pkg::t_item              o_q_item,
    input  wire                         i_q_take
);
    import ccr_pkg::*;

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_eff;
    logic [FRAC_W+CNT_W-1:0]   scaled;
    logic [CNT_W:0]            wrap_sum;
    logic [CNT_W:0]            wrap_idx;
    t_item                     new_item;
    t_item                     r_q [2];
    logic                      r_wp;
    logic                      r_rp;
    logic [1:0]                r_cnt;
    logic                      do_push;
    logic                      do_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_count == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_count > CNT_W'(MAX_POINTS)) begin
            n_eff = CNT_W'(MAX_POINTS);
        end else begin
            n_eff = r_count;
        end
        scaled = i_global_t * n_eff;
        // The segment is below the count, so one subtract finishes the wrap.
        wrap_sum = {1'b0, scaled[FRAC_W+CNT_W-1:FRAC_W]} + {1'b0, n_eff} - (CNT_W+1)'(1);
        wrap_idx = (wrap_sum >= {1'b0, n_eff}) ? wrap_sum - {1'b0, n_eff} : wrap_sum;
        new_item.func      = i_func;
        new_item.slot      = i_point_index;
        new_item.point     = {i_coord_x, i_coord_y, i_coord_z};
        new_item.first_idx = wrap_idx[IDX_W-1:0];
        new_item.count     = n_eff;
        new_item.frac      = scaled[FRAC_W-1:0];
    end

    assign o_full    = (r_cnt == 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_q_take && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= new_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/ccr_back.sv
// Back end: point store access, shared multiply-accumulate and result register.
`timescale 1ns / 1ps
`default_nettype none
module ccr_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_q_valid,
    input  ccr_pkg::t_item              i_q_item,
    output logic                        o_q_take,
    output logic                        o_empty,
    input  wire                         i_pop,
    output logic [ccr_pkg::COORD_W-1:0] o_pos_x,
    output logic [ccr_pkg::COORD_W-1:0] o_pos_y,
    output logic [ccr_pkg::COORD_W-1:0] o_pos_z,
    output logic [ccr_pkg::COORD_W-1:0] o_deriv_x,
    output logic [ccr_pkg::COORD_W-1:0] o_deriv_y,
    output logic [ccr_pkg::COORD_W-1:0] o_deriv_z
);
    import ccr_pkg::*;

    t_state                   r_state, n_state;
    logic [2:0]               r_k, n_k;
    logic [1:0]               r_c, n_c;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic [CNT_W-1:0]         r_n;
    logic [FRAC_W-1:0]        r_u, r_u2, r_u3;
    logic [POINT_W-1:0]       r_pts [4];
    logic signed [COEF_W-1:0] r_a2 [3];
    logic signed [COEF_W-1:0] r_b2 [3];
    logic signed [COEF_W-1:0] r_c2 [3];
    logic signed [ACC_W-1:0]  r_pos [3];
    logic signed [ACC_W-1:0]  r_der [3];
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    t_dst                     r_pdst;
    logic [1:0]               r_pc;
    logic                     r_ovalid;
    logic [COORD_W-1:0]       r_out [6];

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_addr;
    logic [POINT_W-1:0]       ram_rdata;
    logic                     mul_go;
    t_dst                     mul_dst;
    logic signed [COEF_W-1:0] mul_a;
    logic [FRAC_W-1:0]        mul_b;
    logic                     coef_go;
    logic                     out_load;
    logic signed [ACC_W-1:0]  prod_sh;
    logic [COORD_W-1:0]       sat_val [6];
    logic [CNT_W-1:0]         idx_inc;

    ccr_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(i_q_item.point),
        .o_rdata(ram_rdata)
    );

    function automatic logic signed [COEF_W-1:0] coord_of(input logic [POINT_W-1:0] p,
                                                          input logic [1:0] c);
        logic [COORD_W-1:0] v;
        unique case (c)
            2'd0:    v = p[3*COORD_W-1:2*COORD_W];
            2'd1:    v = p[2*COORD_W-1:COORD_W];
            default: v = p[COORD_W-1:0];
        endcase
        return COEF_W'(signed'(v));
    endfunction

    function automatic logic [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] v;
        v = acc >>> 1;
        if (v > ACC_W'(signed'(32'h7fff_ffff))) begin
            return 32'h7fff_ffff;
        end else if (v < ACC_W'(signed'(32'h8000_0000))) begin
            return 32'h8000_0000;
        end
        return v[COORD_W-1:0];
    endfunction

    assign idx_inc = {1'b0, r_idx} + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_c      = r_c;
        n_idx    = r_idx;
        o_q_take = 1'b0;
        ram_we   = 1'b0;
        ram_addr = r_idx;
        mul_go   = 1'b0;
        mul_dst  = DST_U2;
        mul_a    = COEF_W'(r_u);
        mul_b    = r_u;
        coef_go  = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                ram_addr = i_q_item.slot;
                if (i_q_valid) begin
                    o_q_take = 1'b1;
                    if (i_q_item.func == FUNC_WRITE) begin
                        ram_we = 1'b1;
                    end else begin
                        n_idx   = i_q_item.first_idx;
                        n_k     = 3'd0;
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_idx = (idx_inc == r_n) ? '0 : idx_inc[IDX_W-1:0];
                n_k   = r_k + 3'd1;
                if (r_k == 3'd4) begin
                    n_state = ST_COEF;
                end
            end
            ST_COEF: begin
                coef_go = 1'b1;
                n_k     = 3'd0;
                n_state = ST_USQ;
            end
            ST_USQ: begin
                // The u squared product must land before the cube can use it.
                n_k = r_k + 3'd1;
                if (r_k == 3'd0) begin
                    mul_go = 1'b1;
                end else if (r_k == 3'd2) begin
                    mul_go  = 1'b1;
                    mul_dst = DST_U3;
                    mul_a   = COEF_W'(r_u2);
                end
                if (r_k == 3'd3) begin
                    n_k     = 3'd0;
                    n_c     = 2'd0;
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                mul_go = 1'b1;
                unique case (r_k)
                    3'd0: begin
                        mul_dst = DST_POS; mul_a = r_a2[r_c]; mul_b = r_u3;
                    end
                    3'd1: begin
                        mul_dst = DST_POS; mul_a = r_b2[r_c]; mul_b = r_u2;
                    end
                    3'd2: begin
                        mul_dst = DST_POS; mul_a = r_c2[r_c]; mul_b = r_u;
                    end
                    3'd3: begin
                        mul_dst = DST_DER;
                        mul_a   = r_a2[r_c] + (r_a2[r_c] <<< 1);
                        mul_b   = r_u2;
                    end
                    default: begin
                        mul_dst = DST_DER; mul_a = r_b2[r_c] <<< 1; mul_b = r_u;
                    end
                endcase
                n_k = r_k + 3'd1;
                if (r_k == 3'd4) begin
                    n_k = 3'd0;
                    n_c = r_c + 2'd1;
                    if (r_c == 2'd2) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || i_pop) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_c   <= n_c;
        r_idx <= n_idx;
        if (r_state == ST_IDLE) begin
            r_n <= i_q_item.count;
            r_u <= i_q_item.frac;
        end
        if (r_state == ST_READ && r_k != 3'd0) begin
            r_pts[r_k[1:0] - 2'd1] <= ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= mul_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * $signed({2'b00, mul_b});
        r_pdst <= mul_dst;
        r_pc   <= r_c;
    end

    assign prod_sh = r_prod[PROD_W-1:FRAC_W];

    always_ff @(posedge i_clk) begin
        logic signed [COEF_W-1:0] p0, p1, p2, p3;
        for (int c = 0; c < 3; c++) begin
            p0 = coord_of(r_pts[0], 2'(c));
            p1 = coord_of(r_pts[1], 2'(c));
            p2 = coord_of(r_pts[2], 2'(c));
            p3 = coord_of(r_pts[3], 2'(c));
            if (coef_go) begin
                r_a2[c]  <= p3 - p0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2;
                r_b2[c]  <= (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
                r_c2[c]  <= p2 - p0;
                r_pos[c] <= ACC_W'(p1 <<< 1);
                r_der[c] <= ACC_W'(p2 - p0);
            end
        end
        if (r_pv) begin
            unique case (r_pdst)
                DST_U2:  r_u2 <= r_prod[2*FRAC_W-1:FRAC_W];
                DST_U3:  r_u3 <= r_prod[2*FRAC_W-1:FRAC_W];
                DST_POS: r_pos[r_pc] <= r_pos[r_pc] + prod_sh;
                default: r_der[r_pc] <= r_der[r_pc] + prod_sh;
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sat_val[c]     = sat32(r_pos[c]);
            sat_val[3 + c] = sat32(r_der[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int i = 0; i < 6; i++) begin
                r_out[i] <= sat_val[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_pop) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_empty   = !r_ovalid;
    assign o_pos_x   = r_out[0];
    assign o_pos_y   = r_out[1];
    assign o_pos_z   = r_out[2];
    assign o_deriv_x = r_out[3];
    assign o_deriv_y = r_out[4];
    assign o_deriv_z = r_out[5];
endmodule
`default_nettype wire

FILE: rtl/core/closed_catmull_rom_spline_eval_top.sv
// Top level of the closed Catmull-Rom spline evaluator.
`timescale 1ns / 1ps
`default_nettype none
// A write item stores one Q16.16 control point in a 64-entry single-port store
// and is done in the back end as it is taken from the queue. An evaluate item
// is taken from the queue, then the four neighboring points are read through
// the one store port, the curve coefficients are formed, the single shared
// 38x18 multiplier builds u squared, u cubed and then five products per
// coordinate, and the result register is loaded. A result that is not popped
// holds the back end in that last step. The front queue holds two items, so up
// to two items can be pushed while the back end works and while a result waits
// to be popped. The store is not cleared at reset; evaluate only over points
// that have been written.
module closed_catmull_rom_spline_eval_top (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire  [ccr_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  wire                         push,
    output logic                        full,
    input  wire                         i_func,
    input  wire  [ccr_pkg::IDX_W-1:0]   i_point_index,
    input  wire  [ccr_pkg::COORD_W-1:0] i_coord_x,
    input  wire  [ccr_pkg::COORD_W-1:0] i_coord_y,
    input  wire  [ccr_pkg::COORD_W-1:0] i_coord_z,
    input  wire  [ccr_pkg::FRAC_W-1:0]  i_global_t,
    output logic                        empty,
    input  wire                         pop,
    output logic [ccr_pkg::COORD_W-1:0] o_pos_x,
    output logic [ccr_pkg::COORD_W-1:0] o_pos_y,
    output logic [ccr_pkg::COORD_W-1:0] o_pos_z,
    output logic [ccr_pkg::COORD_W-1:0] o_deriv_x,
    output logic [ccr_pkg::COORD_W-1:0] o_deriv_y,
    output logic [ccr_pkg::COORD_W-1:0] o_deriv_z
);
    import ccr_pkg::*;

    logic  q_valid;
    logic  q_take;
    t_item q_item;

    ccr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push       (push),
        .o_full       (full),
        .i_func       (i_func),
        .i_point_index(i_point_index),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .i_global_t   (i_global_t),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item),
        .i_q_take     (q_take)
    );

    ccr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_item (q_item),
        .o_q_take (q_take),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_pos_x  (o_pos_x),
        .o_pos_y  (o_pos_y),
        .o_pos_z  (o_pos_z),
        .o_deriv_x(o_deriv_x),
        .o_deriv_y(o_deriv_y),
        .o_deriv_z(o_deriv_z)
    );
endmodule
`default_nettype wire

FILE: rtl/core/ccr_checker.sv
// Port-level checker for the spline evaluator and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ccr_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        push,
    input wire        full,
    input wire        empty,
    input wire        pop,
    input wire [31:0] o_pos_x,
    input wire [31:0] o_deriv_z
);
    // Reset leaves no result waiting and the input side open.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");
    a_reset_open: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input blocked after reset");
    // An item that is not popped stays on the result ports.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_pos_x) && $stable(o_deriv_z))
        else $error("waiting result changed");
    // An evaluate must first pass through the back end, so a result never appears right after reset.
    a_no_early: assert property (@(posedge i_clk)
        !i_rst_n ##1 i_rst_n |=> empty)
        else $error("result appeared too early");
endmodule

bind closed_catmull_rom_spline_eval_top ccr_checker u_chk (.*);
`default_nettype wire

FILE: test/closed_catmull_rom_spline_eval_top_tb.sv
// Self-checking testbench of the closed Catmull-Rom spline evaluator.
`timescale 1ns / 1ps
module closed_catmull_rom_spline_eval_top_tb;
    import ccr_pkg::*;

    localparam int  CLK_PERIOD  = 10;
    localparam int  DRAIN_WAIT  = 120;
    localparam int  HOLD_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 3000000;

    // Lanes 0..2 hold the position, lanes 3..5 the derivative, each x, y, z.
    typedef logic [5:0][COORD_W-1:0] t_curve_sample;

    typedef struct {
        logic               func;
        logic [IDX_W-1:0]   slot;
        logic [COORD_W-1:0] x, y, z;
        logic [FRAC_W-1:0]  t;
        bit                 known;
        t_curve_sample      want;
    } t_spline_op;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CNT_W-1:0]     i_cfg_wdata;
    logic                 push;
    logic                 full;
    logic                 i_func;
    logic [IDX_W-1:0]     i_point_index;
    logic [COORD_W-1:0]   i_coord_x, i_coord_y, i_coord_z;
    logic [FRAC_W-1:0]    i_global_t;
    logic                 empty;
    logic                 pop;
    logic [COORD_W-1:0]   o_pos_x, o_pos_y, o_pos_z;
    logic [COORD_W-1:0]   o_deriv_x, o_deriv_y, o_deriv_z;

    closed_catmull_rom_spline_eval_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .push(push), .full(full),
        .i_func(i_func), .i_point_index(i_point_index),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .i_global_t(i_global_t),
        .empty(empty), .pop(pop),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_deriv_x(o_deriv_x), .o_deriv_y(o_deriv_y), .o_deriv_z(o_deriv_z)
    );

    longint        ctrl_pts [MAX_POINTS][3];
    logic [CNT_W-1:0] curve_count;
    t_curve_sample expected_samples [$];
    t_spline_op    directed_ops [$];
    int            error_count;
    int            send_idle_pct;
    int            take_idle_pct;
    bit            hold_request;
    longint        cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic logic [COORD_W-1:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[COORD_W-1:0];
    endfunction

    // Position and tangent of the closed curve at global parameter t.
    function automatic t_curve_sample spline_sample(logic [FRAC_W-1:0] t);
        t_curve_sample r;
        longint n, s, seg, u, u2, u3, i0;
        longint p [4];
        longint a, b, c, d, pos, der;
        n = curve_count;
        if (n == 0) n = 1;
        if (n > MAX_POINTS) n = MAX_POINTS;
        s   = longint'(t) * n;
        seg = s >> FRAC_W;
        u   = s & 64'hFFFF;
        u2  = (u * u) >> FRAC_W;
        u3  = (u2 * u) >> FRAC_W;
        i0  = (seg + n - 1) % n;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 4; j++) p[j] = ctrl_pts[(i0 + j) % n][k];
            a = -p[0] + 3 * p[1] - 3 * p[2] + p[3];
            b = 2 * p[0] - 5 * p[1] + 4 * p[2] - p[3];
            c = p[2] - p[0];
            d = 2 * p[1];
            pos = ((a * u3) >>> FRAC_W) + ((b * u2) >>> FRAC_W)
                + ((c * u) >>> FRAC_W) + d;
            der = ((3 * a * u2) >>> FRAC_W) + ((2 * b * u) >>> FRAC_W) + c;
            r[k]     = clip32(pos >>> 1);
            r[3 + k] = clip32(der >>> 1);
        end
        return r;
    endfunction

    // Drives one item and waits until the block takes it. The caller either
    // drives the next item or drops push at the falling edge where this returns.
    task automatic send_op(t_spline_op op);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_func        <= op.func;
        i_point_index <= op.slot;
        i_coord_x     <= op.x;
        i_coord_y     <= op.y;
        i_coord_z     <= op.z;
        i_global_t    <= op.t;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (op.func == FUNC_WRITE) begin
            ctrl_pts[op.slot][0] = longint'($signed(op.x));
            ctrl_pts[op.slot][1] = longint'($signed(op.y));
            ctrl_pts[op.slot][2] = longint'($signed(op.z));
        end else if (op.known) begin
            expected_samples.push_back(op.want);
        end else begin
            expected_samples.push_back(spline_sample(op.t));
        end
        @(negedge i_clk);
    endtask

    // Waits until every result is in and the back end has had time to finish.
    task automatic wait_drained();
        push <= 1'b0;
        while (expected_samples.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic set_count(logic [CNT_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        curve_count = value;
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_spline_op rand_op(int eval_pct);
        t_spline_op op;
        op.func  = ($urandom_range(99) < eval_pct) ? FUNC_EVAL : FUNC_WRITE;
        op.slot  = $urandom_range(MAX_POINTS - 1);
        op.x     = rand_coord();
        op.y     = rand_coord();
        op.z     = rand_coord();
        op.t     = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
        op.known = 1'b0;
        op.want  = '0;
        return op;
    endfunction

    function automatic t_spline_op mk_write(int slot, logic [COORD_W-1:0] v);
        t_spline_op op;
        op = '{FUNC_WRITE, slot[IDX_W-1:0], v, v, v, '0, 1'b0, '0};
        return op;
    endfunction

    // A curve through identical points sits on that point with zero tangent.
    function automatic t_spline_op mk_flat_eval(logic [FRAC_W-1:0] t,
                                                logic [COORD_W-1:0] v);
        t_spline_op op;
        op = '{FUNC_EVAL, '0, '0, '0, '0, t, 1'b1,
               {COORD_W'(0), COORD_W'(0), COORD_W'(0), v, v, v}};
        return op;
    endfunction

    // Receiver: random pops, with a long hold-off on request.
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end
            pop <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_curve_sample got, want;
        if (i_rst_n && pop && !empty) begin
            got = {o_deriv_z, o_deriv_y, o_deriv_x, o_pos_z, o_pos_y, o_pos_x};
            if (expected_samples.size() == 0) begin
                $display("%0t: result with none expected: %h", $time, got);
                error_count++;
            end else begin
                want = expected_samples.pop_front();
                for (int k = 0; k < 6; k++) begin
                    if (got[k] !== want[k]) begin
                        $display("%0t: lane %0d expected %h actual %h",
                                 $time, k, want[k], got[k]);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [CNT_W-1:0] counts [7];
        error_count   = 0;
        cycle_count   = 0;
        hold_request  = 1'b0;
        send_idle_pct = 0;
        take_idle_pct = 0;
        curve_count   = COUNT_RESET;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        push          = 1'b0;
        i_func        = FUNC_WRITE;
        i_point_index = '0;
        i_coord_x     = '0;
        i_coord_y     = '0;
        i_coord_z     = '0;
        i_global_t    = '0;
        foreach (ctrl_pts[i, k]) ctrl_pts[i][k] = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: flat curves at both extremes under the reset count, then
        // alternating extremes where the outputs saturate.
        for (int i = 0; i < 4; i++) directed_ops.push_back(mk_write(i, 32'h7FFF_FFFF));
        directed_ops.push_back(mk_flat_eval(16'h0000, 32'h7FFF_FFFF));
        directed_ops.push_back(mk_flat_eval(16'hFFFF, 32'h7FFF_FFFF));
        for (int i = 0; i < 4; i++) directed_ops.push_back(mk_write(i, 32'h8000_0000));
        directed_ops.push_back(mk_flat_eval(16'h8000, 32'h8000_0000));
        directed_ops.push_back(mk_write(1, 32'h7FFF_FFFF));
        directed_ops.push_back(mk_write(3, 32'h7FFF_FFFF));
        directed_ops.push_back(mk_flat_eval(16'h0000, 32'h0));
        directed_ops[$].known = 1'b0;
        directed_ops.push_back(mk_flat_eval(16'h2000, 32'h0));
        directed_ops[$].known = 1'b0;
        directed_ops.push_back(mk_flat_eval(16'hC123, 32'h0));
        directed_ops[$].known = 1'b0;
        directed_ops.push_back(mk_write(MAX_POINTS - 1, 32'h0001_0000));
        foreach (directed_ops[i]) send_op(directed_ops[i]);

        // Fill the whole store so that no count reads an unwritten point.
        for (int i = 0; i < MAX_POINTS; i++) begin
            t_spline_op op;
            op      = rand_op(0);
            op.slot = i;
            send_op(op);
        end

        // A count of zero acts as one, counts past the table act as full size.
        counts = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd65, 7'd5, 7'd0};
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 45 : 0;
            take_idle_pct = (mode == 0) ? 45 : (mode == 1) ? 35 : 0;
            for (int ph = 0; ph < 7; ph++) begin
                set_count((ph == 6) ? 7'($urandom) : counts[ph]);
                for (int i = 0; i < 95; i++) begin
                    if (mode == 2 && ph == 3 && i == 10) hold_request = 1'b1;
                    if (mode == 1 && ph == 2 && i == 50) wait_drained();
                    send_op(rand_op(75));
                end
            end
        end

        wait_drained();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
